// ===== src/vmrr_pkg.sv =====
// Shared constants, event and status codes, and controller/datapath bundles
// for the round-robin virtual timer scheduler. No dependencies.
`default_nettype none
package vmrr_pkg;

   localparam int MAX_HANDLERS = 8;
   localparam int IDX_W = (MAX_HANDLERS > 1) ? $clog2(MAX_HANDLERS) : 1;
   localparam int CNT_W = $clog2(MAX_HANDLERS + 1);

   localparam logic [15:0] PERIOD_RESET = 16'd10;

   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_PREEMPT  = 2'd1;
   localparam logic [1:0] ACT_YIELD    = 2'd2;
   localparam logic [1:0] ACT_REGISTER = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DUP  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic load;
      logic root_run;
      logic mark_idle;
      logic adv_rr;
      logic resch;
      logic scan_clr;
      logic scan_step;
      logic fin;
   } vmrr_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       from_root;
      logic       empty;
      logic       cur_idle;
      logic       scan_last;
      logic       scan_dup;
   } vmrr_stat_type;

endpackage
`default_nettype wire

// ===== src/vmrr_ctrl.sv =====
// Sequencing state machine for the scheduler: decodes each event and steps
// the datapath through advance, reschedule, table scan and finish. Uses vmrr_pkg.
`default_nettype none
module vmrr_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   output logic                   rsp_valid,
   input  vmrr_pkg::vmrr_stat_type stat,
   output vmrr_pkg::vmrr_cmd_type  cmd
);
   import vmrr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_ADV    = 3'd2;
   localparam logic [2:0] S_RESCH  = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff;
   logic       done;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.action)
               ACT_TICK: begin
                  if (!stat.empty && stat.cur_idle) state_in = S_ADV;
                  else done = 1'b1;
               end
               ACT_PREEMPT: begin
                  if (stat.from_root) begin
                     cmd.root_run = 1'b1;
                     done = 1'b1;
                  end else if (stat.empty) begin
                     done = 1'b1;
                  end else begin
                     state_in = S_ADV;
                  end
               end
               ACT_YIELD: begin
                  cmd.mark_idle = !stat.empty;
                  cmd.scan_clr  = 1'b1;
                  state_in = stat.empty ? S_FIN : S_SCAN;
               end
               default: begin
                  cmd.scan_clr = 1'b1;
                  state_in = stat.empty ? S_FIN : S_SCAN;
               end
            endcase
         end
         S_ADV: begin
            cmd.adv_rr = 1'b1;
            state_in = S_RESCH;
         end
         S_RESCH: begin
            cmd.resch = 1'b1;
            done = 1'b1;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last || stat.scan_dup) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin = 1'b1;
            done = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (done) state_in = S_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= done;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// ===== src/vmrr_datapath.sv =====
// Handler table, scheduler registers, scan unit and result registers.
// Driven by vmrr_ctrl commands; uses vmrr_pkg.
`default_nettype none
module vmrr_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_wr_en,
   input  wire  [15:0]             csr_wr_data,
   input  wire  [1:0]              req_action,
   input  wire                     req_sender_is_root,
   input  wire  [15:0]             req_sender_id,
   input  wire  [15:0]             req_target_id,
   input  wire  [15:0]             req_new_handler_id,
   input  wire  [7:0]              req_owner_vm,
   input  vmrr_pkg::vmrr_cmd_type  cmd,
   output vmrr_pkg::vmrr_stat_type stat,
   output logic                    rsp_run_valid,
   output logic [15:0]             rsp_run_id,
   output logic                    rsp_irq_valid,
   output logic [7:0]              rsp_irq_vm,
   output logic [2:0]              rsp_irq_slot,
   output logic [1:0]              rsp_status
);
   import vmrr_pkg::*;

   logic [15:0]      period_ff;
   logic [31:0]      tick_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] cur_ff;
   logic [IDX_W-1:0] rr_ff;
   logic [MAX_HANDLERS-1:0] idle_ff;

   logic [15:0] thread_ff [MAX_HANDLERS];
   logic [7:0]  vm_ff     [MAX_HANDLERS];
   logic [2:0]  slot_ff   [MAX_HANDLERS];
   logic [15:0] per_ff    [MAX_HANDLERS];
   logic [31:0] last_ff   [MAX_HANDLERS];

   logic [1:0]  action_ff;
   logic        root_ff;
   logic [15:0] sender_ff, target_ff, new_id_ff;
   logic [7:0]  owner_ff;

   logic [IDX_W-1:0] scan_ff, pick_ff;
   logic [15:0]      pick_thread_ff;
   logic             found_ff, dup_ff;
   logic [2:0]       nslot_ff;

   logic             run_valid_ff, irq_valid_ff;
   logic [15:0]      run_id_ff;
   logic [7:0]       irq_vm_ff;
   logic [2:0]       irq_slot_ff;
   logic [1:0]       status_ff;

   logic [IDX_W-1:0] rd_addr;
   logic [15:0]      rd_thread;
   logic [31:0]      elapsed;
   logic [CNT_W-1:0] rr_inc, scan_inc;
   logic             self_yield;
   logic             full;
   logic [IDX_W-1:0] wr_addr;

   assign rd_addr    = cmd.resch ? rr_ff : scan_ff;
   assign rd_thread  = thread_ff[rd_addr];
   assign elapsed    = tick_ff - last_ff[rd_addr];
   assign rr_inc     = CNT_W'(rr_ff) + CNT_W'(1);
   assign scan_inc   = CNT_W'(scan_ff) + CNT_W'(1);
   assign self_yield = (target_ff == 16'd0) || (target_ff == sender_ff);
   assign full       = (count_ff == CNT_W'(MAX_HANDLERS));
   assign wr_addr    = count_ff[IDX_W-1:0];

   assign stat.action    = action_ff;
   assign stat.from_root = root_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.cur_idle  = idle_ff[cur_ff];
   assign stat.scan_last = (scan_inc >= count_ff);
   assign stat.scan_dup  = (action_ff == ACT_REGISTER) && (rd_thread == new_id_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         tick_ff   <= '0;
         count_ff  <= '0;
         cur_ff    <= '0;
         rr_ff     <= '0;
      end else begin
         if (csr_wr_en) period_ff <= csr_wr_data;
         if (cmd.load && (req_action == ACT_TICK)) tick_ff <= tick_ff + 32'd1;
         if (cmd.adv_rr) rr_ff <= (rr_inc >= count_ff) ? '0 : rr_inc[IDX_W-1:0];
         if (cmd.resch) cur_ff <= rr_ff;
         if (cmd.fin && (action_ff == ACT_YIELD) && found_ff) cur_ff <= pick_ff;
         if (cmd.fin && (action_ff == ACT_REGISTER) && !dup_ff && !full)
            count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= req_action;
         root_ff      <= req_sender_is_root;
         sender_ff    <= req_sender_id;
         target_ff    <= req_target_id;
         new_id_ff    <= req_new_handler_id;
         owner_ff     <= req_owner_vm;
         run_valid_ff <= 1'b0;
         run_id_ff    <= '0;
         irq_valid_ff <= 1'b0;
         irq_vm_ff    <= '0;
         irq_slot_ff  <= '0;
         status_ff    <= STAT_OK;
      end
      if (cmd.root_run) begin
         run_valid_ff <= 1'b1;
         run_id_ff    <= sender_ff;
      end
      if (cmd.mark_idle) idle_ff[cur_ff] <= 1'b1;
      if (cmd.resch) begin
         idle_ff[rd_addr] <= 1'b0;
         run_valid_ff     <= 1'b1;
         run_id_ff        <= rd_thread;
         if (elapsed >= {16'd0, per_ff[rd_addr]}) begin
            last_ff[rd_addr] <= tick_ff;
            irq_valid_ff     <= 1'b1;
            irq_vm_ff        <= vm_ff[rd_addr];
            irq_slot_ff      <= slot_ff[rd_addr];
         end
      end
      if (cmd.scan_clr) begin
         scan_ff  <= '0;
         found_ff <= 1'b0;
         dup_ff   <= 1'b0;
         nslot_ff <= '0;
      end
      if (cmd.scan_step) begin
         scan_ff <= scan_inc[IDX_W-1:0];
         if (action_ff == ACT_YIELD) begin
            if (self_yield) begin
               if (!idle_ff[rd_addr]) begin
                  found_ff       <= 1'b1;
                  pick_ff        <= rd_addr;
                  pick_thread_ff <= rd_thread;
               end
            end else if (!found_ff && (rd_thread == target_ff)) begin
               found_ff       <= 1'b1;
               pick_ff        <= rd_addr;
               pick_thread_ff <= rd_thread;
            end
         end else begin
            if (vm_ff[rd_addr] == owner_ff) nslot_ff <= nslot_ff + 3'd1;
            if (rd_thread == new_id_ff) dup_ff <= 1'b1;
         end
      end
      if (cmd.fin) begin
         if (action_ff == ACT_YIELD) begin
            if (found_ff) begin
               run_valid_ff <= 1'b1;
               run_id_ff    <= pick_thread_ff;
            end
         end else if (dup_ff) begin
            status_ff <= STAT_DUP;
         end else if (full) begin
            status_ff <= STAT_FULL;
         end else begin
            thread_ff[wr_addr] <= new_id_ff;
            vm_ff[wr_addr]     <= owner_ff;
            slot_ff[wr_addr]   <= nslot_ff;
            per_ff[wr_addr]    <= period_ff;
            last_ff[wr_addr]   <= '0;
            idle_ff[wr_addr]   <= 1'b0;
         end
      end
   end

   assign rsp_run_valid = run_valid_ff;
   assign rsp_run_id    = run_id_ff;
   assign rsp_irq_valid = irq_valid_ff;
   assign rsp_irq_vm    = irq_vm_ff;
   assign rsp_irq_slot  = irq_slot_ff;
   assign rsp_status    = status_ff;

endmodule
`default_nettype wire

// ===== src/vm_round_robin_vtimer_scheduler.sv =====
// Top level of the round-robin virtual timer scheduler: joins vmrr_ctrl and
// vmrr_datapath. Uses vmrr_pkg.
//
//   channel   ports                         transfer
//   request   start, busy, req_*            start high and busy low at clock edge
//   response  rsp_valid, rsp_*              rsp_valid high for one cycle, no stall
//   csr       csr_wr_en, csr_wr_data        csr_wr_en high at clock edge
//
// Tick, preemption: decode, then advance and reschedule when the pointer moves.
// Yield, register: decode, table scan (register stops at a duplicate), finish;
// the table scan reads one entry per cycle. The response strobe follows in
// the next cycle, when a new request may already transfer.
// Synchronous active-high reset; the response side never stalls.
`default_nettype none
module vm_round_robin_vtimer_scheduler (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_action,
   input  wire         req_sender_is_root,
   input  wire  [15:0] req_sender_id,
   input  wire  [15:0] req_target_id,
   input  wire  [15:0] req_new_handler_id,
   input  wire  [7:0]  req_owner_vm,
   output logic        rsp_valid,
   output logic        rsp_run_valid,
   output logic [15:0] rsp_run_id,
   output logic        rsp_irq_valid,
   output logic [7:0]  rsp_irq_vm,
   output logic [2:0]  rsp_irq_slot,
   output logic [1:0]  rsp_status
);
   import vmrr_pkg::*;

   vmrr_cmd_type  cmd;
   vmrr_stat_type stat;

   vmrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   vmrr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_action         (req_action),
      .req_sender_is_root (req_sender_is_root),
      .req_sender_id      (req_sender_id),
      .req_target_id      (req_target_id),
      .req_new_handler_id (req_new_handler_id),
      .req_owner_vm       (req_owner_vm),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_run_valid      (rsp_run_valid),
      .rsp_run_id         (rsp_run_id),
      .rsp_irq_valid      (rsp_irq_valid),
      .rsp_irq_vm         (rsp_irq_vm),
      .rsp_irq_slot       (rsp_irq_slot),
      .rsp_status         (rsp_status)
   );

endmodule
`default_nettype wire

// ===== src/vmrr_checker.sv =====
// Port-level checks for the scheduler and the bind that attaches them.
// Depends on the top level's ports and the status codes in vmrr_pkg.
`default_nettype none
module vmrr_checker (
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        rsp_valid,
   input wire        rsp_run_valid,
   input wire [15:0] rsp_run_id,
   input wire        rsp_irq_valid,
   input wire [7:0]  rsp_irq_vm,
   input wire [2:0]  rsp_irq_slot,
   input wire [1:0]  rsp_status
);
   import vmrr_pkg::*;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer did not raise busy");

   a_run_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_run_valid) |-> (rsp_run_id == 16'd0))
      else $error("run id without dispatch");

   a_irq_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_irq_valid) |-> (rsp_irq_vm == 8'd0 && rsp_irq_slot == 3'd0))
      else $error("interrupt fields without interrupt");

   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (!rsp_run_valid && !rsp_irq_valid))
      else $error("registration error with dispatch");

endmodule

bind vm_round_robin_vtimer_scheduler vmrr_checker u_vmrr_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_run_valid (rsp_run_valid),
   .rsp_run_id    (rsp_run_id),
   .rsp_irq_valid (rsp_irq_valid),
   .rsp_irq_vm    (rsp_irq_vm),
   .rsp_irq_slot  (rsp_irq_slot),
   .rsp_status    (rsp_status)
);
`default_nettype wire

// ===== test/tb_vm_round_robin_vtimer_scheduler.sv =====
// Testbench for vm_round_robin_vtimer_scheduler: a queue-fed driver, a strobe monitor and an
// in-bench scheduler predictor checked field by field across several timer period settings.
// Depends on vmrr_pkg and the RTL of the block only.
`default_nettype none
module tb_vm_round_robin_vtimer_scheduler;
   import vmrr_pkg::*;

   typedef struct packed {
      logic [1:0]  action;
      logic        from_root;
      logic [15:0] sender;
      logic [15:0] target;
      logic [15:0] new_id;
      logic [7:0]  vm;
   } sched_event_type;

   typedef struct packed {
      logic        run_valid;
      logic [15:0] run_id;
      logic        irq_valid;
      logic [7:0]  irq_vm;
      logic [2:0]  irq_slot;
      logic [1:0]  status;
   } sched_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_TICK;
   logic        req_sender_is_root = 1'b0;
   logic [15:0] req_sender_id = 16'd0;
   logic [15:0] req_target_id = 16'd0;
   logic [15:0] req_new_handler_id = 16'd1;
   logic [7:0]  req_owner_vm = 8'd0;
   logic        rsp_valid;
   logic        rsp_run_valid;
   logic [15:0] rsp_run_id;
   logic        rsp_irq_valid;
   logic [7:0]  rsp_irq_vm;
   logic [2:0]  rsp_irq_slot;
   logic [1:0]  rsp_status;

   vm_round_robin_vtimer_scheduler DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_sender_is_root (req_sender_is_root),
      .req_sender_id      (req_sender_id),
      .req_target_id      (req_target_id),
      .req_new_handler_id (req_new_handler_id),
      .req_owner_vm       (req_owner_vm),
      .rsp_valid          (rsp_valid),
      .rsp_run_valid      (rsp_run_valid),
      .rsp_run_id         (rsp_run_id),
      .rsp_irq_valid      (rsp_irq_valid),
      .rsp_irq_vm         (rsp_irq_vm),
      .rsp_irq_slot       (rsp_irq_slot),
      .rsp_status         (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sched_event_type pending_events[$];
   sched_rsp_type   expected_rsps[$];
   sched_event_type presented;
   int              idle_pct = 0;
   int              err_cnt = 0;
   logic [15:0]     known_ids[$];

   // scheduler state as predicted
   logic [15:0]       period_cfg = PERIOD_RESET;
   logic [31:0]       tick_cnt = '0;
   logic [3:0]        n_handlers = '0;
   logic [IDX_W-1:0]  cur_ent = '0;
   logic [IDX_W-1:0]  rr_ptr = '0;
   logic [15:0]       ent_thread [MAX_HANDLERS];
   logic [7:0]        ent_vm     [MAX_HANDLERS];
   logic [2:0]        ent_slot   [MAX_HANDLERS];
   logic              ent_idle   [MAX_HANDLERS];
   logic [15:0]       ent_period [MAX_HANDLERS];
   logic [31:0]       ent_last   [MAX_HANDLERS];

   initial begin
      for (int i = 0; i < MAX_HANDLERS; i++) begin
         ent_thread[i] = '0;
         ent_vm[i] = '0;
         ent_slot[i] = '0;
         ent_idle[i] = 1'b0;
         ent_period[i] = '0;
         ent_last[i] = '0;
      end
   end

   task automatic advance_round_robin(inout sched_rsp_type o);
      int          nxt;
      logic [31:0] since;
      if (n_handlers == 0) return;
      nxt = int'(rr_ptr) + 1;
      if (nxt >= int'(n_handlers)) nxt = 0;
      rr_ptr = IDX_W'(nxt);
      cur_ent = rr_ptr;
      ent_idle[cur_ent] = 1'b0;
      since = tick_cnt - ent_last[cur_ent];
      if (since >= {16'd0, ent_period[cur_ent]}) begin
         ent_last[cur_ent] = tick_cnt;
         o.irq_valid = 1'b1;
         o.irq_vm = ent_vm[cur_ent];
         o.irq_slot = ent_slot[cur_ent];
      end
      o.run_valid = 1'b1;
      o.run_id = ent_thread[cur_ent];
   endtask

   task automatic predict_event(input sched_event_type ev, output sched_rsp_type o);
      logic             found;
      logic             dup;
      logic [IDX_W-1:0] pick;
      logic [3:0]       slot;
      o = '0;
      found = 1'b0;
      dup = 1'b0;
      pick = '0;
      slot = '0;
      case (ev.action)
         ACT_TICK: begin
            tick_cnt = tick_cnt + 32'd1;
            if (n_handlers != 0 && ent_idle[cur_ent]) advance_round_robin(o);
         end
         ACT_PREEMPT: begin
            if (ev.from_root) begin
               o.run_valid = 1'b1;
               o.run_id = ev.sender;
            end else begin
               advance_round_robin(o);
            end
         end
         ACT_YIELD: begin
            if (n_handlers != 0) ent_idle[cur_ent] = 1'b1;
            if (ev.target == 16'd0 || ev.target == ev.sender) begin
               for (int i = 0; i < n_handlers; i++) begin
                  if (!ent_idle[i]) begin
                     pick = IDX_W'(i);
                     found = 1'b1;
                  end
               end
            end else begin
               for (int i = 0; i < n_handlers; i++) begin
                  if (!found && ent_thread[i] == ev.target) begin
                     pick = IDX_W'(i);
                     found = 1'b1;
                  end
               end
            end
            if (found) begin
               cur_ent = pick;
               o.run_valid = 1'b1;
               o.run_id = ent_thread[pick];
            end
         end
         default: begin
            for (int i = 0; i < n_handlers; i++) begin
               if (!dup) begin
                  if (ent_vm[i] == ev.vm) slot = slot + 4'd1;
                  if (ent_thread[i] == ev.new_id) dup = 1'b1;
               end
            end
            if (dup) begin
               o.status = STAT_DUP;
            end else if (n_handlers >= MAX_HANDLERS) begin
               o.status = STAT_FULL;
            end else begin
               ent_vm[n_handlers] = ev.vm;
               ent_idle[n_handlers] = 1'b0;
               ent_thread[n_handlers] = ev.new_id;
               ent_slot[n_handlers] = slot[2:0];
               ent_period[n_handlers] = period_cfg;
               ent_last[n_handlers] = '0;
               n_handlers = n_handlers + 4'd1;
            end
         end
      endcase
   endtask

   // driver: hold an item until it transfers, then fetch the next one or idle
   always @(posedge clock) begin
      sched_rsp_type o;
      if (!reset) begin
         if (csr_wr_en) period_cfg = csr_wr_data;
         if (start && !busy) begin
            predict_event(presented, o);
            expected_rsps.push_back(o);
         end
         if (!start || !busy) begin
            if (pending_events.size() > 0 && $urandom_range(99) >= idle_pct) begin
               presented = pending_events.pop_front();
               start <= 1'b1;
               req_action <= presented.action;
               req_sender_is_root <= presented.from_root;
               req_sender_id <= presented.sender;
               req_target_id <= presented.target;
               req_new_handler_id <= presented.new_id;
               req_owner_vm <= presented.vm;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         err_cnt++;
         if (err_cnt <= 100)
            $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   // monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsps.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 100)
               $display("%0t result expected none actual run %h irq %h", $time,
                        rsp_run_id, rsp_irq_vm);
         end else begin
            e = expected_rsps.pop_front();
            check_field("run_valid", 16'(e.run_valid), 16'(rsp_run_valid));
            check_field("run_id", e.run_id, rsp_run_id);
            check_field("irq_valid", 16'(e.irq_valid), 16'(rsp_irq_valid));
            check_field("irq_vm", 16'(e.irq_vm), 16'(rsp_irq_vm));
            check_field("irq_slot", 16'(e.irq_slot), 16'(rsp_irq_slot));
            check_field("status", 16'(e.status), 16'(rsp_status));
         end
      end
   end

   function automatic sched_event_type mk(input logic [1:0] action, input logic from_root,
                                          input logic [15:0] sender,
                                          input logic [15:0] target,
                                          input logic [15:0] new_id, input logic [7:0] vm);
      sched_event_type ev;
      ev.action = action;
      ev.from_root = from_root;
      ev.sender = sender;
      ev.target = target;
      ev.new_id = new_id;
      ev.vm = vm;
      return ev;
   endfunction

   function automatic logic is_known(input logic [15:0] id);
      foreach (known_ids[i]) if (known_ids[i] == id) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [15:0] any_known();
      if (known_ids.size() == 0) return 16'($urandom_range(1, 65535));
      return known_ids[$urandom_range(known_ids.size() - 1)];
   endfunction

   function automatic logic [15:0] fresh_id();
      logic [15:0] id;
      id = 16'($urandom_range(1, 65535));
      while (is_known(id)) id = 16'($urandom_range(1, 65535));
      return id;
   endfunction

   task automatic queue_random(input int count, input int new_quota);
      sched_event_type ev;
      int              roll;
      for (int k = 0; k < count; k++) begin
         ev = mk(ACT_TICK, 1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                 16'($urandom_range(1, 65535)), 8'($urandom));
         if ($urandom_range(1)) ev.sender = any_known();
         case ($urandom_range(3))
            0: ev.vm = 8'hFF;
            1: ev.vm = 8'h00;
            2: ev.vm = 8'h03;
            default: ;
         endcase
         roll = $urandom_range(99);
         if (roll < 38) begin
            ev.action = ACT_TICK;
         end else if (roll < 62) begin
            ev.action = ACT_PREEMPT;
         end else if (roll < 85) begin
            ev.action = ACT_YIELD;
            roll = $urandom_range(9);
            if (roll < 3) ev.target = 16'd0;
            else if (roll < 5) ev.target = ev.sender;
            else if (roll < 9) ev.target = any_known();
         end else begin
            ev.action = ACT_REGISTER;
            if (known_ids.size() < MAX_HANDLERS && new_quota > 0 && $urandom_range(1)) begin
               ev.new_id = fresh_id();
               known_ids.push_back(ev.new_id);
               new_quota--;
            end else if (known_ids.size() >= MAX_HANDLERS && $urandom_range(1)) begin
               ev.new_id = fresh_id();
            end else begin
               ev.new_id = any_known();
            end
         end
         pending_events.push_back(ev);
      end
   endtask

   task automatic drain();
      while (pending_events.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_directed(input sched_event_type ev);
      pending_events.push_back(ev);
      if (ev.action == ACT_REGISTER && !is_known(ev.new_id) &&
          known_ids.size() < MAX_HANDLERS)
         known_ids.push_back(ev.new_id);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then first registrations under the reset period
      queue_directed(mk(ACT_TICK, 1'b0, 16'd0, 16'd0, 16'd1, 8'd0));
      queue_directed(mk(ACT_PREEMPT, 1'b0, 16'd9, 16'd0, 16'd1, 8'd0));
      queue_directed(mk(ACT_PREEMPT, 1'b1, 16'hFFFF, 16'd0, 16'd1, 8'd0));
      queue_directed(mk(ACT_PREEMPT, 1'b1, 16'h0000, 16'hFFFF, 16'd1, 8'd0));
      queue_directed(mk(ACT_YIELD, 1'b0, 16'd4, 16'd0, 16'd1, 8'd0));
      queue_directed(mk(ACT_YIELD, 1'b0, 16'd1, 16'd7, 16'd1, 8'd0));
      queue_directed(mk(ACT_REGISTER, 1'b0, 16'd0, 16'd0, 16'hFFFF, 8'hFF));
      queue_directed(mk(ACT_REGISTER, 1'b0, 16'd0, 16'd0, 16'd1, 8'hFF));
      queue_directed(mk(ACT_REGISTER, 1'b1, 16'd0, 16'd0, 16'hFFFF, 8'h00));
      queue_directed(mk(ACT_REGISTER, 1'b0, 16'd0, 16'd0, 16'd2, 8'h00));
      queue_directed(mk(ACT_PREEMPT, 1'b0, 16'd1, 16'd0, 16'd1, 8'd0));
      queue_directed(mk(ACT_TICK, 1'b0, 16'd0, 16'd0, 16'd1, 8'd0));
      queue_directed(mk(ACT_YIELD, 1'b0, 16'd1, 16'd1, 16'd1, 8'd0));
      queue_directed(mk(ACT_YIELD, 1'b0, 16'd5, 16'hFFFF, 16'd1, 8'd0));
      queue_directed(mk(ACT_YIELD, 1'b0, 16'd5, 16'h1234, 16'd1, 8'd0));
      queue_directed(mk(ACT_TICK, 1'b0, 16'd0, 16'd0, 16'd1, 8'd0));

      // zero period: interrupt on every reschedule of that entry
      write_period(16'd0);
      queue_directed(mk(ACT_REGISTER, 1'b0, 16'd0, 16'd0, 16'd3, 8'hFF));
      queue_directed(mk(ACT_PREEMPT, 1'b0, 16'd0, 16'd0, 16'd1, 8'd0));
      queue_directed(mk(ACT_PREEMPT, 1'b0, 16'd0, 16'd0, 16'd1, 8'd0));
      queue_directed(mk(ACT_YIELD, 1'b0, 16'd0, 16'd0, 16'd1, 8'd0));

      write_period(16'd1);
      idle_pct = 0;
      queue_random(250, 1);

      write_period(16'hFFFF);
      idle_pct = 77;
      queue_random(200, 1);

      write_period(16'd0);
      idle_pct = 0;
      queue_random(250, 1);

      write_period(16'($urandom_range(2, 40)));
      idle_pct = 35;
      queue_random(250, 1);

      write_period(PERIOD_RESET);
      idle_pct = 77;
      queue_random(250, 4);

      drain();
      repeat (20) @(posedge clock);
      if (err_cnt == 0) begin
         $display("PASS vm_round_robin_vtimer_scheduler");
      end else begin
         $display("FAIL vm_round_robin_vtimer_scheduler");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL vm_round_robin_vtimer_scheduler");
      $finish;
   end

endmodule
`default_nettype wire
